>>> hdl/clm_pkg.sv
// shared types and constants for the code line map floor lookup
// used by clm_ctrl, clm_dp and code_line_map_floor_lookup
package clm_pkg;

   localparam int MAX_LINES = 1024;
   localparam int IDX_W     = $clog2(MAX_LINES);
   localparam int LINE_W    = IDX_W + 1;
   localparam int MOD_W     = 8;
   localparam int OFF_W     = 32;
   localparam int CNT_W     = 2;
   localparam int ENTRY_W   = LINE_W + MOD_W + OFF_W;
   localparam int REQ_W     = 56;
   localparam int RSP_W     = 56;

   localparam logic [1:0] OP_EMIT   = 2'd0;
   localparam logic [1:0] OP_RECORD = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_PAGE_FULL  = 2'd1;
   localparam logic [1:0] STAT_TABLE_FULL = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND  = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic probe;
      logic check;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic req_lookup;
      logic search_open;
      logic hit;
      logic out_busy;
   } stat_type;

endpackage

>>> hdl/code_line_map_floor_lookup.sv
// code line map floor lookup: one code page with a sorted line-to-module table
// depends on clm_pkg, clm_ctrl and clm_dp (which holds the clm_ram entry table)
//
// req channel takes one word per item: tuser carries the op (emit, record,
// lookup), tdata the emit count, module id, module offset and query line.
// rsp channel returns exactly one word per item: tuser carries the status,
// tdata the found module and offset, the in-page flag and the free line count.
// csr_wen/csr_wdata write the page line count; write only while idle.
// emit, record and reserved words go from acceptance straight to the done state,
// which raises rsp_tvalid once the rsp register is free. a lookup runs a binary
// search over the recorded entries, each probe a ram read, then a compare, at
// most 11 probes for 1024 entries; the done state follows the last probe, or
// the compare on an exact match. the single ram read port serialises the probes.
// one item is in flight at a time; req_tready rises with rsp_tvalid, even
// while that result still waits, so a new word is taken only once the last
// item's result is loaded. a stalled rsp holds its word;
// the next result waits and req_tready stays low until the word is taken.
// reset is synchronous: fill index and entry count go to zero and the page
// size to 1024; the entry ram is not cleared.
module code_line_map_floor_lookup (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wen,
   input  logic [clm_pkg::LINE_W-1:0]   csr_wdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [1:0]                   req_tuser,  // op
   input  logic [clm_pkg::REQ_W-1:0]    req_tdata,  // emit_count, module_id, module_offset, query_line
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [1:0]                   rsp_tuser,  // status
   output logic [clm_pkg::RSP_W-1:0]    rsp_tdata   // found_module, found_offset, in_page, free_lines
);

   clm_pkg::cmd_type  cmd;
   clm_pkg::stat_type stat;

   clm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   clm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

>>> hdl/clm_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module clm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/clm_ctrl.sv
// sequencer for the code line map: accept, binary search probes, result load
// depends on clm_pkg
module clm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  clm_pkg::stat_type stat,
   output clm_pkg::cmd_type  cmd
);

   clm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         clm_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = stat.req_lookup ? clm_pkg::S_SEARCH : clm_pkg::S_DONE;
            end
         end
         clm_pkg::S_SEARCH: begin
            if (stat.search_open) begin
               cmd.probe = 1'b1;
               state_in  = clm_pkg::S_CHECK;
            end else begin
               state_in = clm_pkg::S_DONE;
            end
         end
         clm_pkg::S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.hit ? clm_pkg::S_DONE : clm_pkg::S_SEARCH;
         end
         clm_pkg::S_DONE: begin
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = clm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = clm_pkg::S_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/clm_dp.sv
// datapath: page fill and table counters, entry ram, search bounds, result register
// depends on clm_pkg and clm_ram
module clm_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wen,
   input  logic [clm_pkg::LINE_W-1:0]   csr_wdata,
   input  logic [1:0]                   req_tuser,
   input  logic [clm_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [1:0]                   rsp_tuser,
   output logic [clm_pkg::RSP_W-1:0]    rsp_tdata,
   input  clm_pkg::cmd_type             cmd,
   output clm_pkg::stat_type            stat
);

   localparam int LW = clm_pkg::LINE_W;
   localparam int IW = clm_pkg::IDX_W;
   localparam int MW = clm_pkg::MOD_W;
   localparam int OW = clm_pkg::OFF_W;
   localparam int CW = clm_pkg::CNT_W;

   logic [LW-1:0] page_lines_ff;
   logic [LW-1:0] fill_ff, fill_in;
   logic [LW-1:0] count_ff, count_in;
   logic [LW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [LW-1:0] query_ff;
   logic [1:0]    status_ff, status_in;
   logic [MW-1:0] res_mod_ff, res_mod_in;
   logic [OW-1:0] res_off_ff, res_off_in;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_user_ff;
   logic [clm_pkg::RSP_W-1:0] rsp_data_ff;

   logic [CW-1:0] req_cnt;
   logic [MW-1:0] req_mod;
   logic [OW-1:0] req_off;
   logic [LW-1:0] req_query;
   logic [LW-1:0] cap;
   logic [LW:0]   emit_sum;
   logic          table_full;
   logic          wr_en;
   logic [clm_pkg::ENTRY_W-1:0] wr_data, rd_data;
   logic [LW-1:0] ent_line;
   logic [MW-1:0] ent_mod;
   logic [OW-1:0] ent_off;
   logic [LW-1:0] mid;
   logic [LW-1:0] free_lines;
   logic          in_page;

   assign req_cnt   = req_tdata[1:0];
   assign req_mod   = req_tdata[9:2];
   assign req_off   = req_tdata[41:10];
   assign req_query = req_tdata[52:42];

   assign cap        = (page_lines_ff > LW'(clm_pkg::MAX_LINES)) ?
                       LW'(clm_pkg::MAX_LINES) : page_lines_ff;
   assign emit_sum   = (LW+1)'(fill_ff) + (LW+1)'(req_cnt);
   assign table_full = (count_ff >= cap);
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);

   assign ent_line = rd_data[LW-1:0];
   assign ent_mod  = rd_data[LW+MW-1:LW];
   assign ent_off  = rd_data[LW+MW+OW-1:LW+MW];

   assign wr_en   = cmd.accept && (req_tuser == clm_pkg::OP_RECORD) && !table_full;
   assign wr_data = {req_off, req_mod, fill_ff};

   clm_ram #(
      .WIDTH(clm_pkg::ENTRY_W),
      .DEPTH(clm_pkg::MAX_LINES)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[IW-1:0]),
      .wr_data(wr_data),
      .rd_en  (cmd.probe),
      .rd_addr(mid[IW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      fill_in    = fill_ff;
      count_in   = count_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      status_in  = status_ff;
      res_mod_in = res_mod_ff;
      res_off_in = res_off_ff;
      if (cmd.accept) begin
         lo_in      = '0;
         hi_in      = count_ff;
         res_mod_in = '0;
         res_off_in = '0;
         status_in  = clm_pkg::STAT_OK;
         case (req_tuser)
            clm_pkg::OP_EMIT: begin
               if (emit_sum > (LW+1)'(cap)) begin
                  status_in = clm_pkg::STAT_PAGE_FULL;
               end else begin
                  fill_in = emit_sum[LW-1:0];
               end
            end
            clm_pkg::OP_RECORD: begin
               if (table_full) begin
                  status_in = clm_pkg::STAT_TABLE_FULL;
               end else begin
                  count_in = count_ff + LW'(1);
               end
            end
            clm_pkg::OP_LOOKUP: begin
               status_in = clm_pkg::STAT_NOT_FOUND;
            end
            default: begin
               status_in = clm_pkg::STAT_OK;
            end
         endcase
      end
      if (cmd.probe) begin
         mid_in = mid;
      end
      if (cmd.check) begin
         if (ent_line < query_ff) begin
            lo_in      = mid_ff + LW'(1);
            res_mod_in = ent_mod;
            res_off_in = ent_off;
            status_in  = clm_pkg::STAT_OK;
         end else if (ent_line > query_ff) begin
            hi_in = mid_ff;
         end else begin
            res_mod_in = ent_mod;
            res_off_in = ent_off;
            status_in  = clm_pkg::STAT_OK;
         end
      end
   end

   assign free_lines = (fill_ff >= cap) ? '0 : cap - fill_ff;
   assign in_page    = (query_ff < fill_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         page_lines_ff <= LW'(clm_pkg::MAX_LINES);
         fill_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wen) begin
            page_lines_ff <= csr_wdata;
         end
         fill_ff  <= fill_in;
         count_ff <= count_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      status_ff  <= status_in;
      res_mod_ff <= res_mod_in;
      res_off_ff <= res_off_in;
      if (cmd.accept) begin
         query_ff <= req_query;
      end
      if (cmd.finish) begin
         rsp_user_ff <= status_ff;
         rsp_data_ff <= {4'b0, free_lines, in_page, res_off_ff, res_mod_ff};
      end
   end

   assign stat.req_lookup  = (req_tuser == clm_pkg::OP_LOOKUP);
   assign stat.search_open = (lo_ff < hi_ff);
   assign stat.hit         = (ent_line == query_ff);
   assign stat.out_busy    = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
